/* hw/rtl/tccs_pkg.sv */
// Shared types and constants of the text console cursor and scroll engine.
package tccs_pkg;

  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_NL    = 8'd10;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_SPACE = 8'd32;

  localparam logic [7:0] REG_COLUMNS = 8'd0;
  localparam logic [7:0] REG_ROWS    = 8'd1;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET    = 7'd25;

  typedef struct packed {
    logic [7:0] ch;
  } ch_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic       cell_written;
    logic [6:0] cell_col;
    logic [5:0] cell_row;
    logic [7:0] cell_char;
    logic       scrolled;
  } res_item_t;

  // Clamped grid size in use: cols 1..128, rows 1..64.
  typedef struct packed {
    logic [7:0] cols;
    logic [6:0] rows;
  } dims_t;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_CALC    = 8'b0000_0100,
    ST_WRITE   = 8'b0000_1000,
    ST_SC_RD   = 8'b0001_0000,
    ST_SC_WR   = 8'b0010_0000,
    ST_CLR_ROW = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } seq_state_e;

endpackage

/* hw/rtl/tccs_chan_if.sv */
// Valid/ready channel carrying one payload per transaction.
interface tccs_chan_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/tccs_char_mem.sv */
// Character cell store: one write port, one read port with registered data.
module tccs_char_mem #(
  parameter int ADDR_W = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tccs_cursor.sv */
// Cursor registers and the per-character cursor, wrap and scroll decision.
module tccs_cursor #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         cols_cfg_i,
  input  logic [6:0]         rows_cfg_i,
  input  logic [7:0]         ch_i,
  input  logic               commit_i,
  output tccs_pkg::res_item_t res_o,
  output tccs_pkg::dims_t    dims_o
);
  import tccs_pkg::*;

  localparam int COL_LIM = (MAX_COLS < 128) ? MAX_COLS : 128;
  localparam int ROW_LIM = (MAX_ROWS < 64) ? MAX_ROWS : 64;

  logic [6:0] cur_col_q, cur_col_d;
  logic [5:0] cur_row_q, cur_row_d;
  dims_t      dims;
  res_item_t  res;

  // Saturate the register values into the supported range.
  always_comb begin
    if (cols_cfg_i == 8'd0) begin
      dims.cols = 8'd1;
    end else if (cols_cfg_i > 8'(COL_LIM)) begin
      dims.cols = 8'(COL_LIM);
    end else begin
      dims.cols = cols_cfg_i;
    end
    if (rows_cfg_i == 7'd0) begin
      dims.rows = 7'd1;
    end else if (rows_cfg_i > 7'(ROW_LIM)) begin
      dims.rows = 7'(ROW_LIM);
    end else begin
      dims.rows = rows_cfg_i;
    end
  end

  always_comb begin
    logic [7:0] col;
    logic [6:0] row;
    col = {1'b0, cur_col_q};
    row = {1'b0, cur_row_q};
    res = '0;
    // Pull the cursor back inside a grid that shrank.
    if (col >= dims.cols) begin
      col = dims.cols - 8'd1;
    end
    if (row >= dims.rows) begin
      row = dims.rows - 7'd1;
    end
    if (ch_i == CODE_BS) begin
      if (col != 8'd0) begin
        col              = col - 8'd1;
        res.cell_written = 1'b1;
        res.cell_col     = col[6:0];
        res.cell_row     = row[5:0];
        res.cell_char    = CODE_SPACE;
      end
    end else begin
      if (ch_i == CODE_CR) begin
        col = 8'd0;
      end else if (ch_i == CODE_NL) begin
        col = 8'd0;
        row = row + 7'd1;
      end else begin
        res.cell_written = 1'b1;
        res.cell_col     = col[6:0];
        res.cell_row     = row[5:0];
        res.cell_char    = ch_i;
        col              = col + 8'd1;
      end
      if (col >= dims.cols) begin
        col = 8'd0;
        row = row + 7'd1;
      end
      if (row >= dims.rows) begin
        row          = dims.rows - 7'd1;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_col = col[6:0];
    res.cursor_row = row[5:0];
  end

  assign cur_col_d = commit_i ? res.cursor_col : cur_col_q;
  assign cur_row_d = commit_i ? res.cursor_row : cur_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

  assign res_o  = res;
  assign dims_o = dims;

endmodule

/* hw/rtl/text_console_cursor_scroll.sv */
// Text console engine: cursor, cell store, wrap and scroll sequencer.
//
// Usage:
//   ch_i takes one character code per transaction; res_o returns one result
//   per character (new cursor, the cell stored if any, scroll flag). cfg_i
//   writes columns_in_use (index 0) and rows_in_use (index 1); it is always
//   ready; the user writes it only with no character in flight (unchecked).
// Sequencing:
//   A plain character passes accept, cursor update, cell write and hand-off;
//   its result is registered at hand-off, and the next character is taken
//   only once the last has been handed off. A scroll adds a row copy of
//   cols*(rows-1) cells, each read and then written back through the cell
//   store, plus a pass that blanks the bottom row, with cols and rows the
//   clamped sizes in use. The sequencer works on one character at a time.
// Reset:
//   The cursor goes to (0,0), the sizes to 80 columns by 25 rows, and a
//   clearing pass writes spaces to every cell, one per cycle; ch_i is not
//   ready during that pass.
// Stalls:
//   The result register holds a finished result until res_o is taken; the
//   next character may already be accepted and worked on meanwhile.
module text_console_cursor_scroll #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  tccs_chan_if.sink   ch_i,
  tccs_chan_if.sink   cfg_i,
  tccs_chan_if.source res_o
);
  import tccs_pkg::*;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W = COL_W + ROW_W;

  seq_state_e  state_q, state_d;
  logic [7:0]  cols_q;
  logic [6:0]  rows_q;
  logic [7:0]  ch_q;
  res_item_t   step_res;
  res_item_t   res_q;
  res_item_t   out_q;
  logic        out_valid_q, out_valid_d;
  dims_t       dims;
  logic        commit;
  logic        load_out;

  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [6:0]        scr_col_q, scr_col_d;
  logic [5:0]        scr_row_q, scr_row_d;
  logic              last_col;
  logic              last_copy_row;
  logic [6:0]        src_row;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLUMNS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.payload.index == REG_COLUMNS) begin
        cols_q <= cfg_i.payload.value;
      end else if (cfg_i.payload.index == REG_ROWS) begin
        rows_q <= cfg_i.payload.value[6:0];
      end
    end
  end

  tccs_cursor #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cursor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cols_cfg_i (cols_q),
    .rows_cfg_i (rows_q),
    .ch_i       (ch_q),
    .commit_i   (commit),
    .res_o      (step_res),
    .dims_o     (dims)
  );

  tccs_char_mem #(
    .ADDR_W (ADDR_W)
  ) u_char_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign ch_i.ready    = (state_q == ST_IDLE);
  assign commit        = (state_q == ST_CALC);
  assign last_col      = (scr_col_q == 7'(dims.cols - 8'd1));
  assign src_row       = {1'b0, scr_row_q} + 7'd1;
  assign last_copy_row = (src_row == dims.rows - 7'd1);
  assign load_out      = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  // Cell store port steering.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = CODE_SPACE;
    mem_re    = 1'b0;
    mem_raddr = {ROW_W'(src_row), COL_W'(scr_col_q)};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = res_q.cell_written;
        mem_waddr = {ROW_W'(res_q.cell_row), COL_W'(res_q.cell_col)};
        mem_wdata = res_q.cell_char;
      end
      ST_SC_RD: begin
        mem_re = 1'b1;
      end
      ST_SC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {ROW_W'(scr_row_q), COL_W'(scr_col_q)};
        mem_wdata = mem_rdata;
      end
      ST_CLR_ROW: begin
        mem_we    = 1'b1;
        mem_waddr = {ROW_W'(dims.rows - 7'd1), COL_W'(scr_col_q)};
      end
      ST_IDLE, ST_CALC, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    scr_col_d  = scr_col_q;
    scr_row_d  = scr_row_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ch_i.valid) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        scr_col_d = '0;
        scr_row_d = '0;
        if (!res_q.scrolled) begin
          state_d = ST_DONE;
        end else if (dims.rows == 7'd1) begin
          state_d = ST_CLR_ROW;
        end else begin
          state_d = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        state_d = ST_SC_WR;
      end
      ST_SC_WR: begin
        state_d = ST_SC_RD;
        if (last_col) begin
          scr_col_d = '0;
          if (last_copy_row) begin
            state_d = ST_CLR_ROW;
          end else begin
            scr_row_d = src_row[5:0];
          end
        end else begin
          scr_col_d = scr_col_q + 7'd1;
        end
      end
      ST_CLR_ROW: begin
        scr_col_d = scr_col_q + 7'd1;
        if (last_col) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      scr_col_q   <= '0;
      scr_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      scr_col_q   <= scr_col_d;
      scr_row_q   <= scr_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ch_i.valid && ch_i.ready) begin
      ch_q <= ch_i.payload.ch;
    end
    if (commit) begin
      res_q <= step_res;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  a_copy_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SC_WR) |-> ({1'b0, scr_row_q} < dims.rows - 7'd1) &&
                              ({1'b0, scr_col_q} < dims.cols))
    else $error("row copy outside the grid in use");

  a_scroll_on_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && step_res.scrolled |=> res_q.cursor_row == 6'(dims.rows - 7'd1))
    else $error("scroll left the cursor off the last row");

  a_result_cursor_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> ({1'b0, out_q.cursor_col} < dims.cols) &&
                 ({1'b0, out_q.cursor_row} < dims.rows))
    else $error("result cursor outside the grid in use");

  a_no_cell_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !step_res.cell_written |=>
      (res_q.cell_col == 7'd0) && (res_q.cell_row == 6'd0) && (res_q.cell_char == 8'd0))
    else $error("cell fields set without a stored cell");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_i.valid && ch_i.ready) |=> (state_q == ST_CALC) && !ch_i.ready)
    else $error("character taken while another is in flight");

endmodule

/* tb/text_console_cursor_scroll_tb.sv */
// Self-checking regression of the text console engine: cursor, cell, wrap and scroll reporting.
module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 80000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned CHAR_TARGET    = 850;

  typedef struct {
    bit         is_reg;
    cfg_item_t  reg_wr;
    logic [7:0] code;
    bit         steady;
  } console_op_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  tccs_chan_if #(.payload_t(ch_item_t))  ch_chan ();
  tccs_chan_if #(.payload_t(cfg_item_t)) cfg_chan ();
  tccs_chan_if #(.payload_t(res_item_t)) res_chan ();

  text_console_cursor_scroll DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ch_i   (ch_chan),
    .cfg_i  (cfg_chan),
    .res_o  (res_chan)
  );

  console_op_t console_ops[$];
  res_item_t   console_updates[$];
  console_op_t issue_op;

  // Predictor state: register copies and cursor.
  logic [7:0]  cols_reg;
  logic [6:0]  rows_reg;
  logic [6:0]  cur_col;
  logic [5:0]  cur_row;

  int unsigned chars_queued;
  int unsigned mismatch_count = 0;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned results_seen;
  int unsigned idle_cycles = 0;
  bit          res_free_run;
  bit          phase_steady;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic res_item_t console_step(input logic [7:0] code);
    int unsigned cols, rows, col, row;
    res_item_t   upd;
    cols = (cols_reg == 0) ? 1 : (cols_reg > 128) ? 128 : int'(cols_reg);
    rows = (rows_reg == 0) ? 1 : (rows_reg > 64) ? 64 : int'(rows_reg);
    // Saturate a cursor left outside a shrunken grid.
    col = (cur_col >= cols) ? cols - 1 : int'(cur_col);
    row = (cur_row >= rows) ? rows - 1 : int'(cur_row);
    upd = '0;
    if (code == CODE_BS) begin
      if (col > 0) begin
        col--;
        upd.cell_written = 1'b1;
        upd.cell_col     = 7'(col);
        upd.cell_row     = 6'(row);
        upd.cell_char    = CODE_SPACE;
      end
    end else begin
      if (code == CODE_CR) begin
        col = 0;
      end else if (code == CODE_NL) begin
        col = 0;
        row++;
      end else begin
        upd.cell_written = 1'b1;
        upd.cell_col     = 7'(col);
        upd.cell_row     = 6'(row);
        upd.cell_char    = code;
        col++;
      end
      if (col >= cols) begin
        col = 0;
        row++;
      end
      if (row >= rows) begin
        row          = rows - 1;
        upd.scrolled = 1'b1;
      end
    end
    cur_col        = 7'(col);
    cur_row        = 6'(row);
    upd.cursor_col = cur_col;
    upd.cursor_row = cur_row;
    return upd;
  endfunction

  function automatic void apply_reg_write(input cfg_item_t wr);
    if (wr.index == REG_COLUMNS) cols_reg = wr.value;
    else if (wr.index == REG_ROWS) rows_reg = wr.value[6:0];
  endfunction

  function automatic void check_field(input string label, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [7:0] pick_char(input int unsigned nl_pct, input int unsigned ctl_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < nl_pct) return CODE_NL;
    if (r < nl_pct + ctl_pct / 3) return CODE_CR;
    if (r < nl_pct + ctl_pct) return CODE_BS;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_char(input logic [7:0] code);
    console_op_t op;
    op.is_reg = 1'b0;
    op.reg_wr = '0;
    op.code   = code;
    op.steady = phase_steady;
    console_ops.push_back(op);
    chars_queued++;
  endtask

  task automatic add_reg(input logic [7:0] index, input logic [7:0] value);
    console_op_t op;
    op.is_reg       = 1'b1;
    op.reg_wr.index = index;
    op.reg_wr.value = value;
    op.code         = '0;
    op.steady       = phase_steady;
    console_ops.push_back(op);
  endtask

  task automatic add_phase(input logic [7:0] cols_val, input logic [7:0] rows_val,
                           input int unsigned count, input int unsigned nl_pct,
                           input int unsigned ctl_pct);
    phase_steady = ($urandom_range(0, 3) == 0);
    add_reg(REG_COLUMNS, cols_val);
    add_reg(REG_ROWS, rows_val);
    repeat (count) add_char(pick_char(nl_pct, ctl_pct));
  endtask

  // Driver: issue character and register transactions from the op queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_chan.valid   <= 1'b0;
      ch_chan.payload <= '0;
      cfg_chan.valid  <= 1'b0;
      cfg_chan.payload <= '0;
      cols_reg  = COLUMNS_RESET;
      rows_reg  = ROWS_RESET;
      cur_col   = '0;
      cur_row   = '0;
      hold_left = 0;
    end else begin
      if (ch_chan.valid && ch_chan.ready) console_updates.push_back(console_step(ch_chan.payload.ch));
      if (cfg_chan.valid && cfg_chan.ready) apply_reg_write(cfg_chan.payload);
      if ((ch_chan.valid && !ch_chan.ready) || (cfg_chan.valid && !cfg_chan.ready)) begin
        // hold the current transaction
      end else if (console_ops.size() == 0 || hold_left != 0) begin
        if (hold_left != 0) hold_left--;
        ch_chan.valid  <= 1'b0;
        cfg_chan.valid <= 1'b0;
      end else if (console_ops[0].is_reg) begin
        ch_chan.valid <= 1'b0;
        // Registers change only once every character has reported.
        if (console_updates.size() == 0) begin
          issue_op = console_ops.pop_front();
          cfg_chan.valid   <= 1'b1;
          cfg_chan.payload <= issue_op.reg_wr;
          hold_left = (issue_op.steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        end else begin
          cfg_chan.valid <= 1'b0;
        end
      end else begin
        issue_op = console_ops.pop_front();
        ch_chan.valid      <= 1'b1;
        ch_chan.payload.ch <= issue_op.code;
        cfg_chan.valid     <= 1'b0;
        hold_left = (issue_op.steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      end
    end
  end

  // Monitor: take results with random backpressure and compare.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_chan.ready <= 1'b0;
      stall_left   = 0;
      results_seen = 0;
      res_free_run = 1'b0;
    end else begin
      if (res_chan.valid && res_chan.ready) begin
        if (console_updates.size() == 0) begin
          $display("%0t: unexpected result, cursor (%0d,%0d)", $time,
                   res_chan.payload.cursor_col, res_chan.payload.cursor_row);
          mismatch_count++;
        end else begin
          res_item_t want;
          want = console_updates.pop_front();
          check_field("cursor_col", want.cursor_col, res_chan.payload.cursor_col);
          check_field("cursor_row", want.cursor_row, res_chan.payload.cursor_row);
          check_field("cell_written", want.cell_written, res_chan.payload.cell_written);
          check_field("cell_col", want.cell_col, res_chan.payload.cell_col);
          check_field("cell_row", want.cell_row, res_chan.payload.cell_row);
          check_field("cell_char", want.cell_char, res_chan.payload.cell_char);
          check_field("scrolled", want.scrolled, res_chan.payload.scrolled);
        end
        results_seen++;
        if (results_seen % 64 == 0) res_free_run = ($urandom_range(0, 3) == 0);
      end
      if (stall_left != 0) begin
        stall_left--;
        res_chan.ready <= 1'b0;
      end else begin
        res_chan.ready <= 1'b1;
        if (!res_free_run && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: abort when no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((ch_chan.valid && ch_chan.ready) || (cfg_chan.valid && cfg_chan.ready) ||
          (res_chan.valid && res_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 console_updates.size());
        $display("text_console_cursor_scroll regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  cols_val, rows_val;
    int unsigned pick, mask;
    chars_queued     = 0;
    phase_steady     = 1'b0;

    // Default grid after reset: field extremes and every control code.
    add_char(CODE_BS);
    add_char(8'h41);
    add_char(8'hFF);
    add_char(8'h00);
    add_char(CODE_BS);
    add_char(CODE_CR);
    add_char(CODE_NL);
    add_char(CODE_SPACE);
    add_char(8'h80);
    add_char(8'h7F);
    // Tiny grid: clamp of the old cursor, wrap into scroll, newline scroll.
    add_reg(REG_COLUMNS, 8'd3);
    add_reg(REG_ROWS, 8'd2);
    add_char(8'h61);
    add_char(8'h62);
    add_char(8'h63);
    add_char(8'h64);
    add_char(8'h65);
    add_char(8'h66);
    add_char(CODE_NL);
    add_char(CODE_CR);
    add_char(CODE_BS);
    add_char(8'h78);
    add_char(CODE_BS);

    add_phase(8'd1, 8'd1, 12, 20, 30);
    add_phase(8'd0, 8'd0, 15, 20, 30);
    add_phase(8'd1, 8'hFF, 80, 5, 10);
    add_phase(8'd255, 8'd1, 140, 0, 0);
    add_phase(8'd129, 8'd64, 90, 85, 10);
    add_reg(8'hFE, 8'h55);
    add_phase(COLUMNS_RESET, 8'(ROWS_RESET), 30, 20, 25);

    while (chars_queued < CHAR_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        cols_val = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(129, 255));
        rows_val = 8'($urandom_range(1, 4));
      end else if (pick == 1) begin
        cols_val = 8'($urandom_range(1, 4));
        rows_val = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(65, 127));
      end else begin
        cols_val = 8'($urandom_range(1, 12));
        rows_val = 8'($urandom_range(1, 6));
      end
      phase_steady = ($urandom_range(0, 3) == 0);
      mask = $urandom_range(0, 3);
      if (mask != 1) add_reg(REG_COLUMNS, cols_val);
      if (mask != 0) add_reg(REG_ROWS, rows_val);
      repeat ($urandom_range(20, 50)) add_char(pick_char($urandom_range(15, 40), 25));
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (console_ops.size() != 0 || ch_chan.valid || cfg_chan.valid ||
           console_updates.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && console_updates.size() == 0) begin
      $display("text_console_cursor_scroll regression: pass");
    end else begin
      $display("text_console_cursor_scroll regression: fail");
    end
    $finish;
  end

endmodule
